// ===== rtl/gbos_pkg.sv =====
// gbos_pkg: shared types and constants of the greedy box overlap suppressor
// holds field widths, register indexes, verdict codes and the cell link structs
// depends on nothing
package gbos_pkg;

   // field widths fixed by the interface
   localparam int SCALE_W   = 4;
   localparam int COORD_W   = 12;
   localparam int CFG_W     = 8;
   localparam int PER_W     = 7;
   localparam int SCNT_W    = 8;
   localparam int KIDX_W    = 7;
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [CFG_W-1:0] WIN_WIDTH_RST  = 8'd24;
   localparam logic [CFG_W-1:0] WIN_HEIGHT_RST = 8'd12;
   localparam logic [CFG_W-1:0] MAX_KEPT_RST   = 8'd100;
   localparam logic [PER_W-1:0] MAX_PER_RST    = 7'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIN_WIDTH  = 2'd0,
      CSR_WIN_HEIGHT = 2'd1,
      CSR_MAX_KEPT   = 2'd2,
      CSR_MAX_PER    = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      V_KEPT    = 2'd0,
      V_TOTAL   = 2'd1,
      V_OVERLAP = 2'd2,
      V_SCALE   = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } box_type;

   // probe handed from cell to cell
   typedef struct packed {
      logic    tok;
      logic    hit;
      box_type box;
   } link_type;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
   } win_type;

endpackage

// ===== rtl/gbos_cell.sv =====
// gbos_cell: one slot of the kept-box chain, holds a box and tests the passing probe
// depends on gbos_pkg
module gbos_cell (
   input  logic              clock,
   input  logic              reset,
   input  gbos_pkg::link_type link_in,
   input  gbos_pkg::win_type  win,
   input  logic              active,
   input  logic              wr_en,
   input  gbos_pkg::box_type  wr_box,
   output gbos_pkg::link_type link_out
);
   import gbos_pkg::*;

   box_type             entry_ff;
   logic                tok_ff;
   logic                hit_ff;
   box_type             probe_ff;
   logic [COORD_W-1:0]  dx;
   logic [COORD_W-1:0]  dy;
   logic                match;
   logic                hit_in;

   // distance test against the stored box
   always_comb begin
      dx = (entry_ff.x > link_in.box.x) ? entry_ff.x - link_in.box.x
                                        : link_in.box.x - entry_ff.x;
      dy = (entry_ff.y > link_in.box.y) ? entry_ff.y - link_in.box.y
                                        : link_in.box.y - entry_ff.y;
      match = active && (entry_ff.scale == link_in.box.scale) &&
              (dx < COORD_W'(win.width)) && (dy < COORD_W'(win.height));
      hit_in = link_in.hit || (link_in.tok && match);
   end

   // stored box
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_box;
      end
   end

   // token moves one cell a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= link_in.tok;
      end
   end

   // probe payload and running hit flag
   always_ff @(posedge clock) begin
      hit_ff   <= hit_in;
      probe_ff <= link_in.box;
   end

   assign link_out = '{tok: tok_ff, hit: hit_ff, box: probe_ff};

endmodule

// ===== rtl/gbos_scnt.sv =====
// gbos_scnt: per-scale kept counters in a small memory with valid bits
// depends on gbos_pkg
module gbos_scnt #(
   parameter int SCALE_BINS = 16,
   parameter int AW         = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [gbos_pkg::SCNT_W-1:0] wr_data,
   output logic [gbos_pkg::SCNT_W-1:0] rd_count
);
   import gbos_pkg::*;

   logic [SCNT_W-1:0]     mem [SCALE_BINS];
   logic [SCALE_BINS-1:0] vld_ff;
   logic [SCNT_W-1:0]     rd_data_ff;
   logic                  rd_vld_ff;

   // counter storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // valid bits, cleared at reset and at the start of a set
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // read valid follows the read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (rd_en) begin
         rd_vld_ff <= vld_ff[rd_addr] && !clear;
      end
   end

   assign rd_count = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/greedy_box_overlap_suppressor.sv =====
// greedy_box_overlap_suppressor: top level, control, registers and the cell chain
// depends on gbos_pkg, gbos_cell and gbos_scnt
//
// channel  direction  handshake              payload
// req      in         start high, busy low   req_first_of_set, req_box_scale, req_box_x, req_box_y
// rsp      out        rsp_valid strobe       rsp_verdict, rsp_kept_index
// csr      in         csr_valid, csr_ready   csr_index, csr_wdata
//
// a box walks the chain of MAX_SLOTS cells one cell per cycle; its status strobes and busy
// drops in the same cycle, and the next box can be taken from that cycle on. reset loads the
// register defaults and zeroes all counts; the stored boxes stay undefined but cells at or
// above the kept count are never matched, so no clearing pass is needed. the receiver cannot
// stall; csr_ready is always high.
module greedy_box_overlap_suppressor #(
   parameter int MAX_SLOTS  = 128,
   parameter int SCALE_BINS = 16,
   parameter int COORD_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_first_of_set,
   input  logic [gbos_pkg::SCALE_W-1:0]   req_box_scale,
   input  logic [gbos_pkg::COORD_W-1:0]   req_box_x,
   input  logic [gbos_pkg::COORD_W-1:0]   req_box_y,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_verdict,
   output logic [gbos_pkg::KIDX_W-1:0]    rsp_kept_index,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gbos_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbos_pkg::CFG_W-1:0]     csr_wdata
);
   import gbos_pkg::*;

   localparam int CNTW   = $clog2(MAX_SLOTS + 1);
   localparam int CMPW   = (CNTW > CFG_W) ? CNTW : CFG_W;
   localparam int AW     = (SCALE_BINS > 1) ? $clog2(SCALE_BINS) : 1;
   localparam int CW     = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int NSCALE = 1 << SCALE_W;
   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << CW) - 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [CFG_W-1:0]   win_width_ff;
   logic [CFG_W-1:0]   win_height_ff;
   logic [CFG_W-1:0]   max_kept_ff;
   logic [PER_W-1:0]   max_per_ff;
   logic [CNTW-1:0]    count_ff;
   logic [CNTW-1:0]    count_in;
   box_type            probe_ff;
   logic               tok0_ff;
   logic [AW-1:0]      cidx_ff;
   logic               rsp_valid_ff;
   verdict_type        verdict_ff;
   verdict_type        verdict_in;
   logic [KIDX_W-1:0]  kidx_ff;
   logic [KIDX_W-1:0]  kidx_in;
   logic               accept;
   logic               clear_set;
   logic               decide;
   logic               keep;
   logic [CMPW-1:0]    limit;
   logic [SCNT_W-1:0]  scale_cnt;
   logic [AW-1:0]      cidx_tab [NSCALE];
   link_type           links [MAX_SLOTS+1];
   logic [MAX_SLOTS:0] tok_vec;
   logic [MAX_SLOTS-1:0] active;
   logic [MAX_SLOTS-1:0] wr_sel;
   win_type            win;

   assign accept    = start && !busy;
   assign clear_set = accept && req_first_of_set;
   assign busy      = (state_ff == S_SCAN);
   assign csr_ready = 1'b1;
   assign win       = '{width: win_width_ff, height: win_height_ff};

   // scale to counter index, worked out at elaboration
   for (genvar g = 0; g < NSCALE; g++) begin : g_cidx
      assign cidx_tab[g] = AW'(g % SCALE_BINS);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_width_ff  <= WIN_WIDTH_RST;
         win_height_ff <= WIN_HEIGHT_RST;
         max_kept_ff   <= MAX_KEPT_RST;
         max_per_ff    <= MAX_PER_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_WIN_WIDTH:  win_width_ff  <= csr_wdata;
            CSR_WIN_HEIGHT: win_height_ff <= csr_wdata;
            CSR_MAX_KEPT:   max_kept_ff   <= csr_wdata;
            CSR_MAX_PER:    max_per_ff    <= csr_wdata[PER_W-1:0];
            default: ;
         endcase
      end
   end

   // probe capture at the accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         probe_ff <= '{scale: req_box_scale,
                       x: req_box_x & COORD_MASK,
                       y: req_box_y & COORD_MASK};
         cidx_ff  <= cidx_tab[req_box_scale];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff <= 1'b0;
      end else begin
         tok0_ff <= accept;
      end
   end

   assign links[0] = '{tok: tok0_ff, hit: 1'b0, box: probe_ff};

   // chain of compare cells
   for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
      assign active[g] = (count_ff > CNTW'(g));
      assign wr_sel[g] = keep && (count_ff == CNTW'(g));

      gbos_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (links[g]),
         .win      (win),
         .active   (active[g]),
         .wr_en    (wr_sel[g]),
         .wr_box   (probe_ff),
         .link_out (links[g+1])
      );
   end

   for (genvar g = 0; g <= MAX_SLOTS; g++) begin : g_tok
      assign tok_vec[g] = links[g].tok;
   end

   // per-scale counters
   gbos_scnt #(
      .SCALE_BINS (SCALE_BINS),
      .AW         (AW)
   ) u_scnt (
      .clock    (clock),
      .reset    (reset),
      .clear    (clear_set),
      .rd_en    (accept),
      .rd_addr  (cidx_tab[req_box_scale]),
      .wr_en    (keep),
      .wr_addr  (cidx_ff),
      .wr_data  (scale_cnt + SCNT_W'(1)),
      .rd_count (scale_cnt)
   );

   // verdict once the probe leaves the last cell
   always_comb begin
      decide     = (state_ff == S_SCAN) && links[MAX_SLOTS].tok;
      limit      = (CMPW'(max_kept_ff) < CMPW'(MAX_SLOTS)) ? CMPW'(max_kept_ff)
                                                          : CMPW'(MAX_SLOTS);
      verdict_in = V_KEPT;
      kidx_in    = '0;
      if (CMPW'(count_ff) >= limit) begin
         verdict_in = V_TOTAL;
      end else if (links[MAX_SLOTS].hit) begin
         verdict_in = V_OVERLAP;
      end else if (scale_cnt > SCNT_W'(max_per_ff)) begin
         verdict_in = V_SCALE;
      end else begin
         kidx_in = KIDX_W'(count_ff);
      end
      keep = decide && (verdict_in == V_KEPT);
   end

   // kept count
   always_comb begin
      count_in = count_ff;
      if (clear_set) begin
         count_in = '0;
      end else if (keep) begin
         count_in = count_ff + CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // control state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (decide) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= decide;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (decide) begin
         verdict_ff <= verdict_in;
         kidx_ff    <= kidx_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_verdict    = verdict_ff;
   assign rsp_kept_index = kidx_ff;

   // checks
   a_one_probe: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one probe in the cell chain");

   a_probe_scan: assert property (@(posedge clock) disable iff (reset)
      (tok_vec != '0) |-> (state_ff == S_SCAN))
      else $error("probe in chain while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");

   a_reject_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_verdict != V_KEPT)) |-> (rsp_kept_index == '0))
      else $error("rejected box carries a slot");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_SLOTS))
      else $error("kept count beyond store size");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for greedy_box_overlap_suppressor
// a directed table and then random register phases; every status is checked against the table or a predictor
// depends on gbos_pkg and the rtl top level greedy_box_overlap_suppressor

module tb;
   import gbos_pkg::*;

   localparam int MAX_SLOTS   = 128;
   localparam int SCALE_BINS  = 16;
   localparam int COORD_BITS  = 12;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 2 * (MAX_SLOTS + 1);
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 135;
   localparam int DENSE_ITEMS = 140;

   typedef struct packed {
      verdict_type        verdict;
      logic [KIDX_W-1:0]  slot;
   } status_type;

   // one line of the directed table: a register write or a box
   typedef struct {
      bit                 is_cfg;
      csr_idx_type        idx;
      logic [CFG_W-1:0]   data;
      logic               first;
      logic [SCALE_W-1:0] scale;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      bit                 check;
      verdict_type        verdict;
      logic [KIDX_W-1:0]  slot;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_first_of_set;
   logic [SCALE_W-1:0]   req_box_scale;
   logic [COORD_W-1:0]   req_box_x;
   logic [COORD_W-1:0]   req_box_y;
   logic                 rsp_valid;
   logic [1:0]           rsp_verdict;
   logic [KIDX_W-1:0]    rsp_kept_index;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   // typed expectation that travels with a directed box
   logic                 row_check;
   verdict_type          row_verdict;
   logic [KIDX_W-1:0]    row_slot;

   // predictor copy of the registers and the kept store
   logic [CFG_W-1:0]     win_w;
   logic [CFG_W-1:0]     win_h;
   logic [CFG_W-1:0]     kept_cap;
   logic [PER_W-1:0]     per_cap;
   box_type              kept_store [MAX_SLOTS];
   int unsigned          kept_total;
   logic [SCNT_W-1:0]    scale_kept [SCALE_BINS];

   status_type           pending_status [$];
   row_type              plan [$];
   int                   status_due;
   int                   mismatch_count = 0;
   int                   idle_cycles;

   greedy_box_overlap_suppressor #(
      .MAX_SLOTS  (MAX_SLOTS),
      .SCALE_BINS (SCALE_BINS),
      .COORD_BITS (COORD_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_first_of_set (req_first_of_set),
      .req_box_scale    (req_box_scale),
      .req_box_x        (req_box_x),
      .req_box_y        (req_box_y),
      .rsp_valid        (rsp_valid),
      .rsp_verdict      (rsp_verdict),
      .rsp_kept_index   (rsp_kept_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic void clear_set();
      kept_total = 0;
      foreach (scale_kept[i]) scale_kept[i] = '0;
   endfunction

   // greedy suppression of one box: total limit, then overlap, then per-scale limit
   function automatic status_type judge_box(input logic first, input logic [SCALE_W-1:0] scale,
                                            input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
      status_type  res;
      int unsigned limit;
      int unsigned dx;
      int unsigned dy;
      int unsigned cidx;
      bit          hit;
      hit = 1'b0;
      res.verdict = V_KEPT;
      res.slot = '0;
      if (first) clear_set();
      limit = (kept_cap < MAX_SLOTS) ? 32'(kept_cap) : 32'(MAX_SLOTS);
      cidx = 32'(scale) % SCALE_BINS;
      for (int i = 0; i < kept_total; i++) begin
         if (kept_store[i].scale == scale) begin
            dx = (kept_store[i].x > x) ? 32'(kept_store[i].x - x) : 32'(x - kept_store[i].x);
            dy = (kept_store[i].y > y) ? 32'(kept_store[i].y - y) : 32'(y - kept_store[i].y);
            if (dx < 32'(win_w) && dy < 32'(win_h)) hit = 1'b1;
         end
      end
      if (kept_total >= limit) begin
         res.verdict = V_TOTAL;
      end else if (hit) begin
         res.verdict = V_OVERLAP;
      end else if (scale_kept[cidx] > SCNT_W'(per_cap)) begin
         res.verdict = V_SCALE;
      end else begin
         res.slot = kept_total[KIDX_W-1:0];
         kept_store[kept_total] = '{scale: scale, x: x, y: y};
         kept_total++;
         scale_kept[cidx] = scale_kept[cidx] + SCNT_W'(1);
      end
      return res;
   endfunction

   function automatic void note_fail(input string what);
      if (mismatch_count < 10) $display("%s", what);
      mismatch_count++;
   endfunction

   // predict on each accepted box, check each status strobe, track idle cycles
   always @(posedge clock) begin : scoreboard
      status_type want;
      bit         moved;
      moved = 1'b0;
      if (reset) begin
         win_w    = WIN_WIDTH_RST;
         win_h    = WIN_HEIGHT_RST;
         kept_cap = MAX_KEPT_RST;
         per_cap  = MAX_PER_RST;
         clear_set();
         pending_status.delete();
         status_due  <= 0;
         idle_cycles <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index)
               CSR_WIN_WIDTH:  win_w    = csr_wdata;
               CSR_WIN_HEIGHT: win_h    = csr_wdata;
               CSR_MAX_KEPT:   kept_cap = csr_wdata;
               CSR_MAX_PER:    per_cap  = csr_wdata[PER_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            moved = 1'b1;
            want = judge_box(req_first_of_set, req_box_scale, req_box_x, req_box_y);
            if (row_check) begin
               want.verdict = row_verdict;
               want.slot    = row_slot;
            end
            pending_status.insert(pending_status.size(), want);
         end
         if (rsp_valid) begin
            moved = 1'b1;
            if (pending_status.size() == 0) begin
               note_fail($sformatf("unexpected status: verdict %0d index %0d",
                                   rsp_verdict, rsp_kept_index));
            end else begin
               want = pending_status.pop_front();
               if (rsp_verdict !== want.verdict || rsp_kept_index !== want.slot)
                  note_fail($sformatf("status mismatch: expected %s index %0d, got %0d index %0d",
                                      want.verdict.name(), want.slot,
                                      rsp_verdict, rsp_kept_index));
            end
         end
         status_due  <= pending_status.size();
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin : watchdog
      do @(posedge clock); while (idle_cycles < IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   function automatic row_type box_row(input logic first, input logic [SCALE_W-1:0] scale,
                                       input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                       input bit check, input verdict_type verdict,
                                       input logic [KIDX_W-1:0] slot);
      row_type r;
      r.is_cfg  = 1'b0;
      r.idx     = CSR_WIN_WIDTH;
      r.data    = '0;
      r.first   = first;
      r.scale   = scale;
      r.x       = x;
      r.y       = y;
      r.check   = check;
      r.verdict = verdict;
      r.slot    = slot;
      return r;
   endfunction

   function automatic row_type cfg_row(input csr_idx_type idx, input logic [CFG_W-1:0] data);
      row_type r;
      r.is_cfg  = 1'b1;
      r.idx     = idx;
      r.data    = data;
      r.first   = 1'b0;
      r.scale   = '0;
      r.x       = '0;
      r.y       = '0;
      r.check   = 1'b0;
      r.verdict = V_KEPT;
      r.slot    = '0;
      return r;
   endfunction

   // append one line to the directed table
   function automatic void add_row(input row_type r);
      plan.insert(plan.size(), r);
   endfunction

   // offer one box and hold it until the block takes it; start is left high
   task automatic send_box(input logic first, input logic [SCALE_W-1:0] scale,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input bit check, input verdict_type verdict,
                           input logic [KIDX_W-1:0] slot);
      req_first_of_set <= first;
      req_box_scale    <= scale;
      req_box_x        <= x;
      req_box_y        <= y;
      row_check        <= check;
      row_verdict      <= verdict;
      row_slot         <= slot;
      start            <= 1'b1;
      csr_valid        <= 1'b0;
      do @(posedge clock); while (busy);
   endtask

   // one register transaction; csr_valid is left high for a following write
   task automatic write_reg(input csr_idx_type idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // drain: no box in flight and every status returned
   task automatic wait_idle();
      start     <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (status_due != 0 || busy);
   endtask

   initial begin : stimulus
      int                 set_left;
      int                 spread;
      int                 scale_hi;
      int                 burst_left;
      int                 items;
      int                 pause_at;
      logic [COORD_W-1:0] base_x;
      logic [COORD_W-1:0] base_y;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [SCALE_W-1:0] scale;
      logic               first;
      logic [CFG_W-1:0]   w;
      logic [CFG_W-1:0]   h;
      logic [CFG_W-1:0]   mk;
      logic [CFG_W-1:0]   mp;

      reset            = 1'b1;
      start            = 1'b0;
      req_first_of_set = 1'b0;
      req_box_scale    = '0;
      req_box_x        = '0;
      req_box_y        = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      row_check        = 1'b0;
      row_verdict      = V_KEPT;
      row_slot         = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset registers: window edges on both axes and at the far corner
      add_row(box_row(1'b1, 4'd0, 12'd0, 12'd0, 1'b1, V_KEPT, 7'd0));
      add_row(box_row(1'b0, 4'd0, 12'd23, 12'd11, 1'b1, V_OVERLAP, 7'd0));
      add_row(box_row(1'b0, 4'd0, 12'd24, 12'd0, 1'b1, V_KEPT, 7'd1));
      add_row(box_row(1'b0, 4'd15, 12'd4095, 12'd4095, 1'b1, V_KEPT, 7'd2));
      add_row(box_row(1'b0, 4'd15, 12'd4072, 12'd4084, 1'b1, V_OVERLAP, 7'd0));
      add_row(box_row(1'b0, 4'd1, 12'd0, 12'd0, 1'b1, V_KEPT, 7'd3));
      add_row(box_row(1'b0, 4'd0, 12'd0, 12'd12, 1'b1, V_KEPT, 7'd4));
      add_row(box_row(1'b1, 4'd0, 12'd23, 12'd11, 1'b1, V_KEPT, 7'd0));
      // per-scale limit of zero keeps one box per scale; overlap wins over it
      add_row(cfg_row(CSR_MAX_PER, 8'd0));
      add_row(box_row(1'b1, 4'd3, 12'd100, 12'd100, 1'b1, V_KEPT, 7'd0));
      add_row(box_row(1'b0, 4'd3, 12'd2000, 12'd2000, 1'b1, V_SCALE, 7'd0));
      add_row(box_row(1'b0, 4'd4, 12'd100, 12'd100, 1'b1, V_KEPT, 7'd1));
      add_row(box_row(1'b0, 4'd3, 12'd101, 12'd101, 1'b0, V_KEPT, 7'd0));
      // total limit of zero, then two
      add_row(cfg_row(CSR_MAX_KEPT, 8'd0));
      add_row(box_row(1'b1, 4'd0, 12'd0, 12'd0, 1'b1, V_TOTAL, 7'd0));
      add_row(cfg_row(CSR_MAX_KEPT, 8'd2));
      add_row(cfg_row(CSR_MAX_PER, 8'd127));
      add_row(box_row(1'b1, 4'd5, 12'd0, 12'd0, 1'b1, V_KEPT, 7'd0));
      add_row(box_row(1'b0, 4'd5, 12'd0, 12'd0, 1'b1, V_OVERLAP, 7'd0));
      add_row(box_row(1'b0, 4'd6, 12'd0, 12'd0, 1'b1, V_KEPT, 7'd1));
      add_row(box_row(1'b0, 4'd7, 12'd500, 12'd500, 1'b1, V_TOTAL, 7'd0));
      // zero width or zero height never overlaps
      add_row(cfg_row(CSR_WIN_WIDTH, 8'd0));
      add_row(cfg_row(CSR_WIN_HEIGHT, 8'd255));
      add_row(cfg_row(CSR_MAX_KEPT, 8'd255));
      add_row(box_row(1'b1, 4'd2, 12'd10, 12'd10, 1'b1, V_KEPT, 7'd0));
      add_row(box_row(1'b0, 4'd2, 12'd10, 12'd10, 1'b1, V_KEPT, 7'd1));
      add_row(cfg_row(CSR_WIN_WIDTH, 8'd255));
      add_row(cfg_row(CSR_WIN_HEIGHT, 8'd0));
      add_row(box_row(1'b0, 4'd2, 12'd10, 12'd10, 1'b1, V_KEPT, 7'd2));
      // widest window
      add_row(cfg_row(CSR_WIN_HEIGHT, 8'd255));
      add_row(box_row(1'b0, 4'd2, 12'd264, 12'd10, 1'b0, V_KEPT, 7'd0));
      add_row(box_row(1'b0, 4'd2, 12'd265, 12'd10, 1'b0, V_KEPT, 7'd0));
      add_row(box_row(1'b1, 4'd9, 12'd4095, 12'd0, 1'b1, V_KEPT, 7'd0));

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            wait_idle();
            write_reg(plan[i].idx, plan[i].data);
         end else begin
            send_box(plan[i].first, plan[i].scale, plan[i].x, plan[i].y,
                     plan[i].check, plan[i].verdict, plan[i].slot);
         end
      end

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: {w, h, mk, mp} = {8'd24, 8'd12, 8'd100, 8'd50};
            1: {w, h, mk, mp} = {8'd1, 8'd1, 8'd255, 8'd127};
            2: {w, h, mk, mp} = {8'd255, 8'd255, 8'd128, 8'd0};
            3: {w, h, mk, mp} = {8'd0, 8'd0, 8'd7, 8'd2};
            4: {w, h, mk, mp} = {8'd1, 8'd1, 8'd0, 8'd127};
            5: {w, h, mk, mp} = {8'd255, 8'd1, 8'd128, 8'd255};
            default: begin
               w  = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 40));
               h  = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 40));
               mk = CFG_W'($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom);
               mp = CFG_W'($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom);
            end
         endcase
         wait_idle();
         write_reg(CSR_WIN_WIDTH, w);
         write_reg(CSR_WIN_HEIGHT, h);
         write_reg(CSR_MAX_KEPT, mk);
         write_reg(CSR_MAX_PER, mp);

         items      = (ph == 1) ? DENSE_ITEMS : PHASE_ITEMS;
         set_left   = 0;
         burst_left = 0;
         spread     = 15;
         scale_hi   = 0;
         base_x     = '0;
         base_y     = '0;
         pause_at   = $urandom_range(1, items - 1);
         for (int k = 0; k < items; k++) begin
            if (k == pause_at) wait_idle();
            if (ph == 1) begin
               // one long set with a point-sized window fills the store
               first = (k == 0);
               scale = SCALE_W'($urandom);
               x     = COORD_W'($urandom);
               y     = COORD_W'($urandom);
            end else if ($urandom_range(0, 9) == 0) begin
               first = 1'($urandom_range(0, 1));
               scale = SCALE_W'($urandom);
               x     = COORD_W'($urandom);
               y     = COORD_W'($urandom);
            end else begin
               // clustered set so that overlaps and limits are reached
               if (set_left == 0) begin
                  set_left = $urandom_range(1, 60);
                  case ($urandom_range(0, 2))
                     0: spread = 15;
                     1: spread = 63;
                     default: spread = 4095;
                  endcase
                  base_x   = COORD_W'($urandom);
                  base_y   = COORD_W'($urandom);
                  scale_hi = $urandom_range(0, 15);
                  first    = 1'b1;
               end else begin
                  first = 1'b0;
               end
               set_left--;
               scale = SCALE_W'($urandom_range(0, scale_hi));
               x     = base_x + COORD_W'($urandom_range(0, spread));
               y     = base_y + COORD_W'($urandom_range(0, spread));
            end

            // sender idling: bursts with start held, or a gap after busy drops
            if (burst_left > 0) begin
               burst_left--;
            end else if ($urandom_range(0, 15) == 0) begin
               burst_left = $urandom_range(5, 30);
            end else if ($urandom_range(0, 1)) begin
               start <= 1'b0;
               do @(posedge clock); while (busy);
               repeat ($urandom_range(0, 10)) @(posedge clock);
            end
            send_box(first, scale, x, y, 1'b0, V_KEPT, '0);
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_status.size() != 0) note_fail("status transactions never arrived");
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
